// ===== hw/rtl/gmc_pkg.sv =====
`default_nettype none

package gmc_pkg;

    localparam int DEF_MAX_ROWS       = 128;
    localparam int DEF_MAX_COLS       = 128;
    localparam int DEF_FRONTIER_DEPTH = 16384;

    localparam int RAND_W     = 31;
    localparam int COORD_W    = 7;
    localparam int COUNT_W    = 15;
    localparam int CFG_DATA_W = 8;
    localparam int SPACING_W  = 4;

    // modulo unit retires two dividend bits per cycle
    localparam int DIV_PAD_W = RAND_W + (RAND_W % 2);
    localparam int DIV_STEPS = DIV_PAD_W / 2;

    typedef logic [1:0] cfg_addr_t;

    localparam cfg_addr_t CFG_GRID_HEIGHT  = 2'd0;
    localparam cfg_addr_t CFG_GRID_WIDTH   = 2'd1;
    localparam cfg_addr_t CFG_CELL_SPACING = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_GRID_HEIGHT  = 8'd99;
    localparam logic [CFG_DATA_W-1:0] RST_GRID_WIDTH   = 8'd99;
    localparam logic [SPACING_W-1:0]  RST_CELL_SPACING = 4'd2;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_LEFT,
        DIR_DOWN,
        DIR_RIGHT
    } dir_t;

    typedef enum logic [1:0] {
        RES_START,
        RES_EMPTY,
        RES_CARVE,
        RES_DROP
    } res_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_LOAD,
        ST_PROBE,
        ST_CHECK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_DROP_RD,
        ST_DROP_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gmc_divider.sv =====
`default_nettype none

module gmc_divider #(
    parameter int DW = 15
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [gmc_pkg::RAND_W-1:0] dividend,
    input  wire logic [DW-1:0]             divisor,
    output gmc_pkg::div_status_t           status,
    output logic [DW-1:0]                  remainder
);

    import gmc_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_PAD_W-1:0] bits_reg, bits_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        dvs_reg, dvs_next;

    logic [DW:0] trial1, trial2, part1, part2;

    always_comb
    begin
        trial1 = {rem_reg, bits_reg[DIV_PAD_W-1]};
        part1  = (trial1 >= {1'b0, dvs_reg}) ? trial1 - {1'b0, dvs_reg} : trial1;
        trial2 = {part1[DW-1:0], bits_reg[DIV_PAD_W-2]};
        part2  = (trial2 >= {1'b0, dvs_reg}) ? trial2 - {1'b0, dvs_reg} : trial2;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bits_next = bits_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bits_next = DIV_PAD_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            bits_next = bits_reg << 2;
            rem_next  = part2[DW-1:0];
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/grid_maze_carver.sv =====
`default_nettype none

// Growing-tree maze carver. The visited bitmap is a row-wide memory (MAX_ROWS words of
// MAX_COLS bits) and the frontier list a FRONTIER_DEPTH-word memory, both with registered
// reads. A start word (cmd 0) runs a clearing pass over the bitmap, one row per cycle.
// A growth word on an empty frontier goes straight to the result load. Any other growth
// word runs the accept, the random-mod-count pick (2 dividend bits per cycle), the frontier
// fetch and the result load, plus a probe, and a check when the target is in the grid, per
// direction tried, plus either a read and write of the last entry for a removal or a read
// and write per bitmap row marked on a carve: one row for a horizontal carve, spacing + 1
// for a vertical one. A new word is taken while the previous result waits at the output.
module grid_maze_carver #(
    parameter int MAX_ROWS       = gmc_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS       = gmc_pkg::DEF_MAX_COLS,
    parameter int FRONTIER_DEPTH = gmc_pkg::DEF_FRONTIER_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire gmc_pkg::cfg_addr_t            cfg_index,
    input  wire logic [gmc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic [gmc_pkg::RAND_W-1:0]     rand_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               carved,
    output logic [gmc_pkg::COORD_W-1:0]         from_row,
    output logic [gmc_pkg::COORD_W-1:0]         from_col,
    output logic [1:0]                         direction,
    output logic [gmc_pkg::COORD_W-1:0]         to_row,
    output logic [gmc_pkg::COORD_W-1:0]         to_col,
    output logic [gmc_pkg::COUNT_W-1:0]         frontier_count,
    output logic                               done_res
);

    import gmc_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int FW  = $clog2(FRONTIER_DEPTH);
    localparam int SW  = $clog2(FRONTIER_DEPTH + 1);
    localparam int XR  = RW + SPACING_W + 1;
    localparam int XC  = CW + SPACING_W + 1;
    localparam int EW  = RW + CW;

    // configuration
    logic [CFG_DATA_W-1:0] grid_height_reg, grid_width_reg;
    logic [SPACING_W-1:0]  cell_spacing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_height_reg  <= RST_GRID_HEIGHT;
            grid_width_reg   <= RST_GRID_WIDTH;
            cell_spacing_reg <= RST_CELL_SPACING;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_GRID_HEIGHT:  grid_height_reg  <= cfg_data;
                CFG_GRID_WIDTH:   grid_width_reg   <= cfg_data;
                CFG_CELL_SPACING: cell_spacing_reg <= cfg_data[SPACING_W-1:0];
                default: ;
            endcase
        end
    end

    logic [RCW-1:0]       rows_eff;
    logic [CCW-1:0]       cols_eff;
    logic [SPACING_W-1:0] sp_eff;
    logic [RW-1:0]        center_row;
    logic [CW-1:0]        center_col;

    always_comb
    begin
        if (grid_height_reg == '0)
            rows_eff = RCW'(1);
        else if (32'(grid_height_reg) > 32'(MAX_ROWS))
            rows_eff = RCW'(MAX_ROWS);
        else
            rows_eff = RCW'(grid_height_reg);
        if (grid_width_reg == '0)
            cols_eff = CCW'(1);
        else if (32'(grid_width_reg) > 32'(MAX_COLS))
            cols_eff = CCW'(MAX_COLS);
        else
            cols_eff = CCW'(grid_width_reg);
        sp_eff     = (cell_spacing_reg == '0) ? SPACING_W'(1) : cell_spacing_reg;
        center_row = RW'(rows_eff >> 1);
        center_col = CW'(cols_eff >> 1);
    end

    // control and datapath registers
    state_t          state_reg, state_next;
    res_kind_t       kind_reg, kind_next;
    dir_t            dir_reg, dir_next;
    logic [1:0]      tries_reg, tries_next;
    logic [SW-1:0]   size_reg, size_next;
    logic [FW-1:0]   pick_reg, pick_next;
    logic [RW-1:0]   fr_reg, fr_next;
    logic [CW-1:0]   fc_reg, fc_next;
    logic [RW-1:0]   clr_row_reg, clr_row_next;
    logic [RW-1:0]   mark_row_reg, mark_row_next;
    logic [SPACING_W-1:0] mark_left_reg, mark_left_next;
    logic            out_valid_reg, out_valid_next;

    logic               out_carved_reg;
    logic [COORD_W-1:0] out_from_row_reg, out_from_col_reg;
    logic [COORD_W-1:0] out_to_row_reg, out_to_col_reg;
    logic [1:0]         out_dir_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_done_reg;
    logic               out_load;

    // memories
    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] grid_q_reg;
    logic                g_we, g_re;
    logic [RW-1:0]       g_waddr, g_raddr;
    logic [MAX_COLS-1:0] g_wdata;

    logic [EW-1:0]       front_mem [FRONTIER_DEPTH];
    logic [EW-1:0]       f_q_reg;
    logic                f_we, f_re;
    logic [FW-1:0]       f_waddr, f_raddr;
    logic [EW-1:0]       f_wdata;

    always_ff @(posedge clk)
    begin
        if (g_we)
            grid_mem[g_waddr] <= g_wdata;
        if (g_re)
            grid_q_reg <= grid_mem[g_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
            front_mem[f_waddr] <= f_wdata;
        if (f_re)
            f_q_reg <= front_mem[f_raddr];
    end

    // modulo unit
    logic         div_start;
    div_status_t  div_stat;
    logic [SW-1:0] div_rem;

    gmc_divider #(
        .DW(SW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rand_value),
        .divisor   (size_reg),
        .status    (div_stat),
        .remainder (div_rem)
    );

    // target cell for the current direction
    logic [XR-1:0] fr_x, nr_x, rows_x, sp_xr;
    logic [XC-1:0] fc_x, nc_x, cols_x, sp_xc;
    logic          tgt_neg, tgt_ok;
    logic [RW-1:0] tgt_row;
    logic [CW-1:0] tgt_col;

    always_comb
    begin
        fr_x    = XR'(fr_reg);
        fc_x    = XC'(fc_reg);
        rows_x  = XR'(rows_eff);
        cols_x  = XC'(cols_eff);
        sp_xr   = XR'(sp_eff);
        sp_xc   = XC'(sp_eff);
        nr_x    = fr_x;
        nc_x    = fc_x;
        tgt_neg = 1'b0;
        case (dir_reg)
            DIR_UP:
            begin
                tgt_neg = fr_x < sp_xr;
                nr_x    = fr_x - sp_xr;
            end
            DIR_LEFT:
            begin
                tgt_neg = fc_x < sp_xc;
                nc_x    = fc_x - sp_xc;
            end
            DIR_DOWN:  nr_x = fr_x + sp_xr;
            DIR_RIGHT: nc_x = fc_x + sp_xc;
            default: ;
        endcase
        tgt_ok  = !tgt_neg && (nr_x < rows_x) && (nc_x < cols_x);
        tgt_row = RW'(nr_x);
        tgt_col = CW'(nc_x);
    end

    // columns touched in the row being marked
    logic [CW-1:0]       mask_lo, mask_hi;
    logic [MAX_COLS-1:0] mark_mask;

    always_comb
    begin
        case (dir_reg)
            DIR_LEFT:
            begin
                mask_lo = tgt_col;
                mask_hi = fc_reg;
            end
            DIR_RIGHT:
            begin
                mask_lo = fc_reg;
                mask_hi = tgt_col;
            end
            default:
            begin
                mask_lo = fc_reg;
                mask_hi = fc_reg;
            end
        endcase
        for (int j = 0; j < MAX_COLS; j++)
            mark_mask[j] = (CW'(j) >= mask_lo) && (CW'(j) <= mask_hi);
    end

    logic accept, probe_free, last_try, front_full, out_free, carve_now;

    assign accept     = in_valid && in_ready;
    assign probe_free = !grid_q_reg[tgt_col];
    assign last_try   = tries_reg == 2'd3;
    assign front_full = size_reg == SW'(FRONTIER_DEPTH);
    assign out_free   = !out_valid_reg || out_ready;
    assign carve_now  = (state_reg == ST_CHECK) && probe_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (!cmd)
                        state_next = ST_CLEAR;
                    else if (size_reg == '0)
                        state_next = ST_FINISH;
                    else
                        state_next = ST_DIV;
                end
            ST_CLEAR:
                if (clr_row_reg == RW'(MAX_ROWS - 1))
                    state_next = ST_FINISH;
            ST_DIV:
                if (div_stat.done)
                    state_next = ST_LOAD;
            ST_LOAD:
                state_next = front_full ? ST_DROP_RD : ST_PROBE;
            ST_PROBE:
                if (tgt_ok)
                    state_next = ST_CHECK;
                else if (last_try)
                    state_next = ST_DROP_RD;
            ST_CHECK:
                if (probe_free)
                    state_next = ST_MARK_RD;
                else if (last_try)
                    state_next = ST_DROP_RD;
                else
                    state_next = ST_PROBE;
            ST_MARK_RD:
                state_next = ST_MARK_WR;
            ST_MARK_WR:
                if (mark_left_reg == '0)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MARK_RD;
            ST_DROP_RD:
                state_next = ST_DROP_WR;
            ST_DROP_WR:
                state_next = ST_FINISH;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        kind_next      = kind_reg;
        dir_next       = dir_reg;
        tries_next     = tries_reg;
        size_next      = size_reg;
        pick_next      = pick_reg;
        fr_next        = fr_reg;
        fc_next        = fc_reg;
        clr_row_next   = clr_row_reg;
        mark_row_next  = mark_row_reg;
        mark_left_next = mark_left_reg;
        div_start      = 1'b0;
        out_load       = 1'b0;
        g_we           = 1'b0;
        g_re           = 1'b0;
        g_waddr        = mark_row_reg;
        g_raddr        = mark_row_reg;
        g_wdata        = grid_q_reg | mark_mask;
        f_we           = 1'b0;
        f_re           = 1'b0;
        f_waddr        = pick_reg;
        f_raddr        = pick_reg;
        f_wdata        = f_q_reg;

        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    dir_next   = dir_t'(rand_value[1:0]);
                    tries_next = '0;
                    if (!cmd)
                    begin
                        kind_next    = RES_START;
                        clr_row_next = '0;
                        size_next    = SW'(1);
                        f_we         = 1'b1;
                        f_waddr      = '0;
                        f_wdata      = {center_row, center_col};
                    end
                    else if (size_reg == '0)
                        kind_next = RES_EMPTY;
                    else
                        div_start = 1'b1;
                end
            ST_CLEAR:
            begin
                g_we         = 1'b1;
                g_waddr      = clr_row_reg;
                g_wdata      = (clr_row_reg == center_row) ?
                               (MAX_COLS'(1) << center_col) : '0;
                clr_row_next = clr_row_reg + RW'(1);
            end
            ST_DIV:
                if (div_stat.done)
                begin
                    f_re      = 1'b1;
                    f_raddr   = FW'(div_rem);
                    pick_next = FW'(div_rem);
                end
            ST_LOAD:
            begin
                fr_next = f_q_reg[EW-1:CW];
                fc_next = f_q_reg[CW-1:0];
            end
            ST_PROBE:
                if (tgt_ok)
                begin
                    g_re    = 1'b1;
                    g_raddr = tgt_row;
                end
                else
                begin
                    tries_next = tries_reg + 2'd1;
                    dir_next   = dir_t'(dir_reg + 2'd1);
                end
            ST_CHECK:
                if (probe_free)
                begin
                    kind_next      = RES_CARVE;
                    f_we           = 1'b1;
                    f_waddr        = FW'(size_reg);
                    f_wdata        = {tgt_row, tgt_col};
                    size_next      = size_reg + SW'(1);
                    mark_row_next  = fr_reg;
                    mark_left_next = (dir_reg == DIR_UP || dir_reg == DIR_DOWN) ?
                                     sp_eff : '0;
                end
                else
                begin
                    tries_next = tries_reg + 2'd1;
                    dir_next   = dir_t'(dir_reg + 2'd1);
                end
            ST_MARK_RD:
                g_re = 1'b1;
            ST_MARK_WR:
            begin
                g_we           = 1'b1;
                mark_left_next = mark_left_reg - SPACING_W'(1);
                mark_row_next  = (dir_reg == DIR_UP) ? mark_row_reg - RW'(1) :
                                                       mark_row_reg + RW'(1);
            end
            ST_DROP_RD:
            begin
                // last entry moves into the removed slot
                kind_next = RES_DROP;
                f_re      = 1'b1;
                f_raddr   = FW'(size_reg - SW'(1));
                size_next = size_reg - SW'(1);
            end
            ST_DROP_WR:
                f_we = 1'b1;
            ST_FINISH:
                out_load = out_free;
            default: ;
        endcase
    end

    assign out_valid_next = (out_valid_reg && !out_ready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        dir_reg       <= dir_next;
        tries_reg     <= tries_next;
        pick_reg      <= pick_next;
        fr_reg        <= fr_next;
        fc_reg        <= fc_next;
        clr_row_reg   <= clr_row_next;
        mark_row_reg  <= mark_row_next;
        mark_left_reg <= mark_left_next;
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_count_reg <= COUNT_W'(size_reg);
            out_done_reg  <= size_reg == '0;
            case (kind_reg)
                RES_START:
                begin
                    out_carved_reg   <= 1'b0;
                    out_from_row_reg <= COORD_W'(center_row);
                    out_from_col_reg <= COORD_W'(center_col);
                    out_dir_reg      <= DIR_UP;
                    out_to_row_reg   <= COORD_W'(center_row);
                    out_to_col_reg   <= COORD_W'(center_col);
                end
                RES_CARVE:
                begin
                    out_carved_reg   <= 1'b1;
                    out_from_row_reg <= COORD_W'(fr_reg);
                    out_from_col_reg <= COORD_W'(fc_reg);
                    out_dir_reg      <= dir_reg;
                    out_to_row_reg   <= COORD_W'(tgt_row);
                    out_to_col_reg   <= COORD_W'(tgt_col);
                end
                RES_DROP:
                begin
                    out_carved_reg   <= 1'b0;
                    out_from_row_reg <= COORD_W'(fr_reg);
                    out_from_col_reg <= COORD_W'(fc_reg);
                    out_dir_reg      <= DIR_UP;
                    out_to_row_reg   <= '0;
                    out_to_col_reg   <= '0;
                end
                default:
                begin
                    out_carved_reg   <= 1'b0;
                    out_from_row_reg <= '0;
                    out_from_col_reg <= '0;
                    out_dir_reg      <= DIR_UP;
                    out_to_row_reg   <= '0;
                    out_to_col_reg   <= '0;
                end
            endcase
        end
    end

    assign in_ready       = state_reg == ST_IDLE;
    assign out_valid      = out_valid_reg;
    assign carved         = out_carved_reg;
    assign from_row       = out_from_row_reg;
    assign from_col       = out_from_col_reg;
    assign direction      = out_dir_reg;
    assign to_row         = out_to_row_reg;
    assign to_col         = out_to_col_reg;
    assign frontier_count = out_count_reg;
    assign done_res       = out_done_reg;

    a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (div_rem < size_reg))
        else $error("frontier pick not below frontier size");

    a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle modulo unit");

    a_carve_grows: assert property (@(posedge clk) disable iff (!rst_n)
        carve_now |=> (size_reg == $past(size_reg) + SW'(1)))
        else $error("carve did not append a frontier entry");

    a_drop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DROP_RD) |=> (size_reg == $past(size_reg) - SW'(1)))
        else $error("removal did not shrink the frontier");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import gmc_pkg::*;

    localparam int MAX_R          = DEF_MAX_ROWS;
    localparam int MAX_C          = DEF_MAX_COLS;
    localparam int DEPTH          = DEF_FRONTIER_DEPTH;
    localparam int RANDOM_WORDS   = 750;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 80;
    localparam int LONG_HOLD      = 400;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    localparam logic OP_START = 1'b0;
    localparam logic OP_GROW  = 1'b1;

    typedef struct packed {
        logic               carved;
        logic [COORD_W-1:0] from_row;
        logic [COORD_W-1:0] from_col;
        dir_t               direction;
        logic [COORD_W-1:0] to_row;
        logic [COORD_W-1:0] to_col;
        logic [COUNT_W-1:0] frontier_count;
        logic               done;
    } carve_word_t;

    localparam carve_word_t EMPTY_STEP = '{1'b0, 7'd0, 7'd0, DIR_UP, 7'd0, 7'd0, 15'd0, 1'b1};

    typedef enum logic {
        PLAN_GRID,
        PLAN_WORD
    } plan_kind_t;

    typedef struct {
        plan_kind_t        kind;
        logic [7:0]        height;
        logic [7:0]        width;
        logic [7:0]        spacing;
        logic              op;
        logic [RAND_W-1:0] rnd;
        bit                typed;
        carve_word_t       known;
    } plan_row_t;

    typedef enum logic [1:0] {
        FLOW_OPEN,
        FLOW_HALF,
        FLOW_SPARSE,
        FLOW_MOSTLY
    } flow_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    cfg_addr_t             cfg_index = CFG_GRID_HEIGHT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  cmd = OP_START;
    logic [RAND_W-1:0]     rand_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  carved;
    logic [COORD_W-1:0]    from_row;
    logic [COORD_W-1:0]    from_col;
    logic [1:0]            direction;
    logic [COORD_W-1:0]    to_row;
    logic [COORD_W-1:0]    to_col;
    logic [COUNT_W-1:0]    frontier_count;
    logic                  done_res;

    grid_maze_carver u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .rand_value     (rand_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .carved         (carved),
        .from_row       (from_row),
        .from_col       (from_col),
        .direction      (direction),
        .to_row         (to_row),
        .to_col         (to_col),
        .frontier_count (frontier_count),
        .done_res       (done_res)
    );

    // shadow of the maze state
    logic [7:0]        height_reg = RST_GRID_HEIGHT;
    logic [7:0]        width_reg = RST_GRID_WIDTH;
    logic [3:0]        spacing_reg = RST_CELL_SPACING;
    logic [MAX_C-1:0]  visited [MAX_R];
    logic [13:0]       frontier [DEPTH];
    int unsigned       frontier_len = 0;

    carve_word_t carves_due[$];
    plan_row_t   plan[$];

    int burst_left = 0;
    int words_sent = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int settings_used = 0;
    int long_holds = 0;
    int starts_seen = 0;
    int carves_seen = 0;
    int drops_seen = 0;
    int empties_seen = 0;
    int frontier_peak = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout: %0d words sent, %0d results seen", words_sent, results_seen);
        $display("== FAIL ==");
        $finish;
    end

    function automatic carve_word_t grow_maze(input logic op, input logic [RAND_W-1:0] rnd);
        carve_word_t res;
        int rows, cols, sp, pick, fr, fc, nr, nc, dr, dc, d, i, k;
        bit hit;
        res = '0;
        rows = (height_reg == 0) ? 1 : (height_reg > MAX_R) ? MAX_R : int'(height_reg);
        cols = (width_reg == 0) ? 1 : (width_reg > MAX_C) ? MAX_C : int'(width_reg);
        sp = (spacing_reg == 0) ? 1 : int'(spacing_reg);
        if (op == OP_START)
        begin
            for (i = 0; i < MAX_R; i++)
                visited[i] = '0;
            fr = rows / 2;
            fc = cols / 2;
            visited[fr][fc] = 1'b1;
            frontier[0] = {7'(fr), 7'(fc)};
            frontier_len = 1;
            res.from_row = 7'(fr);
            res.from_col = 7'(fc);
            res.to_row = 7'(fr);
            res.to_col = 7'(fc);
            res.frontier_count = 15'd1;
            starts_seen++;
            return res;
        end
        if (frontier_len == 0)
        begin
            empties_seen++;
            return EMPTY_STEP;
        end
        pick = int'(rnd % frontier_len);
        fr = int'(frontier[pick][13:7]);
        fc = int'(frontier[pick][6:0]);
        hit = 1'b0;
        // a full list refuses every direction
        if (frontier_len < DEPTH)
        begin
            for (i = 0; i < 4 && !hit; i++)
            begin
                d = (int'(rnd[1:0]) + i) % 4;
                dr = (d == DIR_UP) ? -1 : (d == DIR_DOWN) ? 1 : 0;
                dc = (d == DIR_LEFT) ? -1 : (d == DIR_RIGHT) ? 1 : 0;
                nr = fr + sp * dr;
                nc = fc + sp * dc;
                if (nr >= 0 && nr < rows && nc >= 0 && nc < cols && !visited[nr][nc])
                begin
                    hit = 1'b1;
                    frontier[frontier_len] = {7'(nr), 7'(nc)};
                    frontier_len++;
                    for (k = 0; k <= sp; k++)
                        visited[fr + k * dr][fc + k * dc] = 1'b1;
                    res.carved = 1'b1;
                    res.direction = dir_t'(d);
                    res.to_row = 7'(nr);
                    res.to_col = 7'(nc);
                    carves_seen++;
                end
            end
        end
        if (!hit)
        begin
            // swap the last entry into the dead one's slot
            frontier_len--;
            frontier[pick] = frontier[frontier_len];
            drops_seen++;
        end
        res.from_row = 7'(fr);
        res.from_col = 7'(fc);
        res.frontier_count = 15'(frontier_len);
        res.done = (frontier_len == 0);
        if (frontier_len > frontier_peak)
            frontier_peak = frontier_len;
        return res;
    endfunction

    function automatic plan_row_t grid_row(input logic [7:0] h, input logic [7:0] w,
                                           input logic [7:0] s);
        plan_row_t row;
        row = '{kind: PLAN_GRID, height: h, width: w, spacing: s, op: OP_GROW, rnd: '0,
                typed: 1'b0, known: '0};
        return row;
    endfunction

    function automatic plan_row_t word_row(input logic op, input logic [RAND_W-1:0] rnd,
                                           input bit typed, input carve_word_t known);
        plan_row_t row;
        row = '{kind: PLAN_WORD, height: '0, width: '0, spacing: '0, op: op, rnd: rnd,
                typed: typed, known: known};
        return row;
    endfunction

    task automatic send_word(input logic op, input logic [RAND_W-1:0] rnd, input bit typed,
                             input carve_word_t known);
        carve_word_t predicted;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(1, 30);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= op;
        rand_value <= rnd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = grow_maze(op, rnd);
        carves_due.push_back(typed ? known : predicted);
        words_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (carves_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_grid(input logic [7:0] h, input logic [7:0] w, input logic [7:0] s);
        cfg_write_en <= 1'b1;
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_index <= CFG_GRID_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= CFG_CELL_SPACING;
        cfg_data <= s;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        height_reg = h;
        width_reg = w;
        spacing_reg = s[3:0];
        settings_used++;
    endtask

    // receiver: changing stall patterns, plus long hold-offs while words keep coming
    initial begin : result_sink
        flow_mode_t mode;
        int mode_left;
        mode = FLOW_OPEN;
        mode_left = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (long_holds < 2 && results_seen >= 150 + long_holds * 300 && in_valid)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_holds++;
            end
            if (mode_left == 0)
            begin
                mode = flow_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 120);
            end
            mode_left--;
            case (mode)
                FLOW_OPEN:   out_ready <= 1'b1;
                FLOW_HALF:   out_ready <= ($urandom_range(0, 1) == 0);
                FLOW_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
                default:     out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        carve_word_t want;
        string bad;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (carves_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %0d: carved=%0d from=(%0d,%0d)",
                             results_seen, carved, from_row, from_col);
            end
            else
            begin
                want = carves_due.pop_front();
                bad = "";
                if (want.carved !== carved) bad = {bad, " carved"};
                if (want.from_row !== from_row) bad = {bad, " from_row"};
                if (want.from_col !== from_col) bad = {bad, " from_col"};
                if (want.direction !== direction) bad = {bad, " direction"};
                if (want.to_row !== to_row) bad = {bad, " to_row"};
                if (want.to_col !== to_col) bad = {bad, " to_col"};
                if (want.frontier_count !== frontier_count) bad = {bad, " frontier_count"};
                if (want.done !== done_res) bad = {bad, " done_res"};
                if (bad != "")
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("result word %0d wrong in:%s", results_seen, bad);
                        $display("  expected carved=%0d from=(%0d,%0d) dir=%0d to=(%0d,%0d) count=%0d done=%0d",
                                 want.carved, want.from_row, want.from_col, want.direction,
                                 want.to_row, want.to_col, want.frontier_count, want.done);
                        $display("  got      carved=%0d from=(%0d,%0d) dir=%0d to=(%0d,%0d) count=%0d done=%0d",
                                 carved, from_row, from_col, direction, to_row, to_col,
                                 frontier_count, done_res);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int directed_words, steps, i;
        logic [7:0] dim_extremes [4];
        logic [3:0] spacing_extremes [3];
        logic [7:0] h, w;
        logic [3:0] sp;
        dim_extremes = '{8'd0, 8'd1, 8'd128, 8'd255};
        spacing_extremes = '{4'd0, 4'd1, 4'd15};

        for (i = 0; i < MAX_R; i++)
            visited[i] = '0;

        // before any start, then a maze on the reset grid
        plan.push_back(word_row(OP_GROW, 31'd0, 1'b1, EMPTY_STEP));
        plan.push_back(word_row(OP_START, 31'h7FFF_FFFF, 1'b1,
                                '{1'b0, 7'd49, 7'd49, DIR_UP, 7'd49, 7'd49, 15'd1, 1'b0}));
        plan.push_back(word_row(OP_GROW, 31'd0, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'd1, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'd2, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'd3, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'h7FFF_FFFF, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'h5555_5555, 1'b0, '0));
        // zero dimensions and zero spacing act as a 1x1 grid at spacing 1
        plan.push_back(grid_row(8'd0, 8'd0, 8'd0));
        plan.push_back(word_row(OP_START, 31'd0, 1'b1,
                                '{1'b0, 7'd0, 7'd0, DIR_UP, 7'd0, 7'd0, 15'd1, 1'b0}));
        plan.push_back(word_row(OP_GROW, 31'h7FFF_FFFF, 1'b1,
                                '{1'b0, 7'd0, 7'd0, DIR_UP, 7'd0, 7'd0, 15'd0, 1'b1}));
        plan.push_back(word_row(OP_GROW, 31'h2AAA_AAAA, 1'b1, EMPTY_STEP));
        // oversize dimensions clamp to the maximum; upper spacing bits are ignored
        plan.push_back(grid_row(8'd255, 8'd255, 8'hFF));
        plan.push_back(word_row(OP_START, 31'h1234_5678, 1'b1,
                                '{1'b0, 7'd64, 7'd64, DIR_UP, 7'd64, 7'd64, 15'd1, 1'b0}));
        plan.push_back(word_row(OP_GROW, 31'd0, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'd1, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'd2, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'd3, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'h7FFF_FFFF, 1'b0, '0));
        // shrink to one column without restarting: old cells fall outside the grid
        plan.push_back(grid_row(8'd128, 8'd1, 8'd1));
        plan.push_back(word_row(OP_GROW, 31'h0F0F_0F0F, 1'b0, '0));
        plan.push_back(word_row(OP_START, 31'd0, 1'b1,
                                '{1'b0, 7'd64, 7'd0, DIR_UP, 7'd64, 7'd0, 15'd1, 1'b0}));
        plan.push_back(word_row(OP_GROW, 31'd2, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'h4000_0000, 1'b0, '0));
        plan.push_back(grid_row(8'd3, 8'd3, 8'd1));
        plan.push_back(word_row(OP_START, 31'h0000_FFFF, 1'b1,
                                '{1'b0, 7'd1, 7'd1, DIR_UP, 7'd1, 7'd1, 15'd1, 1'b0}));
        plan.push_back(word_row(OP_GROW, 31'h7FFF_FFFE, 1'b0, '0));
        plan.push_back(word_row(OP_GROW, 31'd1, 1'b0, '0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[n])
        begin
            if (plan[n].kind == PLAN_GRID)
            begin
                settle();
                program_grid(plan[n].height, plan[n].width, plan[n].spacing);
            end
            else
                send_word(plan[n].op, plan[n].rnd, plan[n].typed, plan[n].known);
        end
        directed_words = words_sent;

        // random mazes: mostly small grids, now and then large or out-of-range ones
        while (words_sent < directed_words + RANDOM_WORDS)
        begin
            settle();
            case ($urandom_range(0, 9))
                0:
                begin
                    h = dim_extremes[$urandom_range(0, 3)];
                    w = dim_extremes[$urandom_range(0, 3)];
                    sp = spacing_extremes[$urandom_range(0, 2)];
                end
                1, 2, 3, 4, 5, 6:
                begin
                    h = 8'($urandom_range(1, 12));
                    w = 8'($urandom_range(1, 12));
                    sp = 4'($urandom_range(1, 3));
                end
                default:
                begin
                    h = 8'($urandom_range(1, 128));
                    w = 8'($urandom_range(1, 128));
                    sp = 4'($urandom_range(1, 15));
                end
            endcase
            program_grid(h, w, {4'($urandom_range(0, 15)), sp});
            // sometimes keep growing the old maze under the new settings
            if ($urandom_range(0, 7) != 0)
                send_word(OP_START, RAND_W'($urandom), 1'b0, '0);
            steps = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(4, 50);
            repeat (steps)
                send_word(($urandom_range(0, 19) == 0) ? OP_START : OP_GROW,
                          RAND_W'($urandom), 1'b0, '0);
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d words over %0d grid settings: %0d starts, %0d carves, %0d removals, %0d empty steps.",
                 words_sent, settings_used, starts_seen, carves_seen, drops_seen, empties_seen);
        $display("Deepest frontier %0d entries; receiver held off %0d times; %0d mismatches.",
                 frontier_peak, long_holds, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/gmc_pkg.sv
hw/rtl/gmc_divider.sv
hw/rtl/grid_maze_carver.sv
bench/tb.sv
